[hw/rtl/bbc_pkg.sv]
// Shared types, constants and character decode for the bracket balance checker.
package bbc_pkg;

  localparam int STACK_DEPTH   = 64;
  localparam int POSITION_BITS = 16;

  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int POS_W   = 16;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;

  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

  localparam logic [STAT_W-1:0] ST_BALANCED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_CLOSE_EMPTY = 3'd1;
  localparam logic [STAT_W-1:0] ST_WRONG_KIND  = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNCLOSED    = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVERFLOW    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  localparam logic [7:0] CH_TERM     = 8'h00;
  localparam logic [7:0] CH_RND_OPEN  = 8'h28;
  localparam logic [7:0] CH_RND_CLOSE = 8'h29;
  localparam logic [7:0] CH_CRL_OPEN  = 8'h7b;
  localparam logic [7:0] CH_CRL_CLOSE = 8'h7d;
  localparam logic [7:0] CH_SQR_OPEN  = 8'h5b;
  localparam logic [7:0] CH_SQR_CLOSE = 8'h5d;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
  } entry_t;

  typedef struct packed {
    logic              load;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  pos;
    logic [KIND_W-1:0] kind;
  } result_t;

  function automatic logic [KIND_W-1:0] open_kind(input logic [7:0] c);
    case (c)
      CH_RND_OPEN: open_kind = KIND_ROUND;
      CH_CRL_OPEN: open_kind = KIND_CURLY;
      CH_SQR_OPEN: open_kind = KIND_SQUARE;
      default:     open_kind = KIND_NONE;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] close_kind(input logic [7:0] c);
    case (c)
      CH_RND_CLOSE: close_kind = KIND_ROUND;
      CH_CRL_CLOSE: close_kind = KIND_CURLY;
      CH_SQR_CLOSE: close_kind = KIND_SQUARE;
      default:      close_kind = KIND_NONE;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pos_field(input logic [POSITION_BITS-1:0] idx);
    logic [POSITION_BITS+POS_W-1:0] wide;
    wide = {{POS_W{1'b0}}, idx};
    pos_field = wide[POS_W-1:0];
  endfunction

endpackage

[hw/rtl/bbc_ram.sv]
// Generic simple dual-port RAM with registered read.
module bbc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bbc_ctrl.sv]
// Stack control: character decode, push and pop, error latch and result build.
module bbc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          ch,
  output bbc_pkg::result_t    res
);

  logic [bbc_pkg::DEPTH_W-1:0]       depth;
  logic [bbc_pkg::DEPTH_W-1:0]       depth_next;
  logic [bbc_pkg::POSITION_BITS-1:0] char_index;
  logic                              err_seen;
  logic [bbc_pkg::STAT_W-1:0]        err_status;
  logic [bbc_pkg::POS_W-1:0]         err_pos;
  logic [bbc_pkg::KIND_W-1:0]        err_kind;
  bbc_pkg::entry_t                   top;
  bbc_pkg::entry_t                   top_next;
  bbc_pkg::entry_t                   below;
  bbc_pkg::entry_t                   new_entry;

  logic [bbc_pkg::KIND_W-1:0]  ok;
  logic [bbc_pkg::KIND_W-1:0]  ck;
  logic [bbc_pkg::POS_W-1:0]   cur_pos;
  logic                        term;
  logic                        live;
  logic                        push;
  logic                        pop;
  logic                        err_new;
  logic [bbc_pkg::STAT_W-1:0]  err_new_status;
  logic [bbc_pkg::DEPTH_W-1:0] rd_sum;
  logic [bbc_pkg::ADDR_W-1:0]  raddr;

  assign ok      = bbc_pkg::open_kind(ch);
  assign ck      = bbc_pkg::close_kind(ch);
  assign cur_pos = bbc_pkg::pos_field(char_index);
  assign term    = (ch == bbc_pkg::CH_TERM);
  assign live    = take && !term && !err_seen;

  assign new_entry.kind = ok;
  assign new_entry.pos  = cur_pos;

  always_comb begin
    push           = 1'b0;
    pop            = 1'b0;
    err_new        = 1'b0;
    err_new_status = bbc_pkg::ST_BALANCED;
    if (live && ok != bbc_pkg::KIND_NONE) begin
      if (depth == bbc_pkg::DEPTH_FULL) begin
        err_new        = 1'b1;
        err_new_status = bbc_pkg::ST_OVERFLOW;
      end else begin
        push = 1'b1;
      end
    end else if (live && ck != bbc_pkg::KIND_NONE) begin
      if (depth == '0) begin
        err_new        = 1'b1;
        err_new_status = bbc_pkg::ST_CLOSE_EMPTY;
      end else if (top.kind == ck) begin
        pop = 1'b1;
      end else begin
        err_new        = 1'b1;
        err_new_status = bbc_pkg::ST_WRONG_KIND;
      end
    end
  end

  always_comb begin
    depth_next = depth;
    top_next   = top;
    if (take && term) begin
      depth_next = '0;
    end else if (push) begin
      depth_next = depth + 1'b1;
      top_next   = new_entry;
    end else if (pop) begin
      depth_next = depth - 1'b1;
      top_next   = below;
    end
  end

  // prefetch the entry under the next top
  assign rd_sum = depth_next - bbc_pkg::DEPTH_W'(2);
  assign raddr  = rd_sum[bbc_pkg::ADDR_W-1:0];

  bbc_ram #(
    .Width ($bits(bbc_pkg::entry_t)),
    .Depth (bbc_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (depth[bbc_pkg::ADDR_W-1:0]),
    .wdata (new_entry),
    .raddr (raddr),
    .rdata (below)
  );

  always_ff @(posedge clk) begin
    top <= top_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= '0;
      char_index <= '0;
      err_seen   <= 1'b0;
      err_status <= bbc_pkg::ST_BALANCED;
      err_pos    <= '0;
      err_kind   <= bbc_pkg::KIND_ROUND;
    end else begin
      depth <= depth_next;
      if (take && term) begin
        char_index <= '0;
        err_seen   <= 1'b0;
        err_status <= bbc_pkg::ST_BALANCED;
        err_pos    <= '0;
        err_kind   <= bbc_pkg::KIND_ROUND;
      end else begin
        if (take && char_index != '1) begin
          char_index <= char_index + 1'b1;
        end
        if (err_new) begin
          err_seen   <= 1'b1;
          err_status <= err_new_status;
          err_pos    <= cur_pos;
          err_kind   <= (err_new_status == bbc_pkg::ST_OVERFLOW) ? ok : ck;
        end
      end
    end
  end

  always_comb begin
    res.load   = take && term;
    res.status = bbc_pkg::ST_BALANCED;
    res.pos    = '0;
    res.kind   = bbc_pkg::KIND_ROUND;
    if (err_seen) begin
      res.status = err_status;
      res.pos    = err_pos;
      res.kind   = err_kind;
    end else if (depth != '0) begin
      res.status = bbc_pkg::ST_UNCLOSED;
      res.pos    = top.pos;
      res.kind   = top.kind;
    end
  end

`ifndef ASSERT_OFF
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (take && term) |=> (depth == '0 && !err_seen && char_index == '0))
    else $error("state not cleared after terminator");

  a_err_holds: assert property (@(posedge clk) disable iff (rst)
    (err_seen && !(take && term)) |=> (err_seen && $stable(err_status) && $stable(err_pos)))
    else $error("latched error changed before terminator");

  a_depth_step: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(depth))
    else $error("stack depth moved without a transfer");

  a_no_push_after_err: assert property (@(posedge clk) disable iff (rst)
    err_seen |-> !push && !pop)
    else $error("stack touched after first error");
`endif

endmodule

[hw/rtl/bracket_balance_checker.sv]
// Bracket balance checker: one character per cycle, nesting check over a RAM-held stack.
// The block takes one character per cycle unless stalled. Each opening bracket pushes
// its kind and position onto a 64-entry stack kept in a RAM; the top entry sits in a
// register and the entry beneath it is prefetched from the RAM every cycle, so a push or
// pop per character never waits. A zero byte ends an expression; its result (status,
// position, bracket kind) appears on the result channel on the cycle after the terminator
// transfer, and the stack and counters are clear for the next character in that same
// cycle. Characters are taken while the result register is empty or being drained; only a
// stalled, full result register holds the character channel. No clearing pass follows reset.
module bracket_balance_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       char_valid,
  output logic                       char_stall,
  input  logic [7:0]                 ch,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [bbc_pkg::STAT_W-1:0] status,
  output logic [bbc_pkg::POS_W-1:0]  position,
  output logic [bbc_pkg::KIND_W-1:0] bracket_kind
);

  bbc_pkg::result_t res;
  logic             take;

  assign char_stall = result_valid && result_stall;
  assign take       = char_valid && !char_stall;

  bbc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .ch   (ch),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      status       <= res.status;
      position     <= res.pos;
      bracket_kind <= res.kind;
    end
  end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the bracket balance checker with a class-based scoreboard.
`timescale 1ns / 100ps

module testbench;
  import bbc_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_CHARS  = 470;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  pos;
    logic [KIND_W-1:0] kind;
  } verdict_t;

  class bracket_scoreboard;
    entry_t                   open_stack[$];
    logic [POSITION_BITS-1:0] char_idx;
    bit                       fault_seen;
    verdict_t                 fault;
    verdict_t                 verdict_q[$];
    int                       mismatches;
    int                       verdicts_checked;
    int                       expressions;
    int                       status_tally[5];

    function new();
      clear_expression();
    endfunction

    function void clear_expression();
      open_stack.delete();
      char_idx   = '0;
      fault_seen = 1'b0;
      fault      = '0;
    endfunction

    function void classify(input logic [7:0] c, output bit opens, output bit closes,
                           output logic [KIND_W-1:0] k);
      opens  = 1'b0;
      closes = 1'b0;
      k      = KIND_NONE;
      case (c)
        CH_RND_OPEN: begin
          opens = 1'b1;
          k     = KIND_ROUND;
        end
        CH_CRL_OPEN: begin
          opens = 1'b1;
          k     = KIND_CURLY;
        end
        CH_SQR_OPEN: begin
          opens = 1'b1;
          k     = KIND_SQUARE;
        end
        CH_RND_CLOSE: begin
          closes = 1'b1;
          k      = KIND_ROUND;
        end
        CH_CRL_CLOSE: begin
          closes = 1'b1;
          k      = KIND_CURLY;
        end
        CH_SQR_CLOSE: begin
          closes = 1'b1;
          k      = KIND_SQUARE;
        end
        default: ;
      endcase
    endfunction

    function void latch_fault(logic [STAT_W-1:0] st, logic [KIND_W-1:0] k);
      fault_seen = 1'b1;
      fault      = '{st, POS_W'(char_idx), k};
    endfunction

    function void note_char(logic [7:0] c);
      verdict_t          v;
      bit                opens;
      bit                closes;
      logic [KIND_W-1:0] k;
      if (c == CH_TERM) begin
        if (fault_seen) v = fault;
        else if (open_stack.size() > 0)
          v = '{ST_UNCLOSED, open_stack[$].pos, open_stack[$].kind};
        else v = '{ST_BALANCED, POS_W'(0), KIND_ROUND};
        verdict_q.push_back(v);
        expressions++;
        clear_expression();
        return;
      end
      classify(c, opens, closes, k);
      if (!fault_seen) begin
        if (opens) begin
          if (open_stack.size() >= STACK_DEPTH) latch_fault(ST_OVERFLOW, k);
          else open_stack.push_back('{k, POS_W'(char_idx)});
        end else if (closes) begin
          if (open_stack.size() == 0) latch_fault(ST_CLOSE_EMPTY, k);
          else if (open_stack[$].kind == k) void'(open_stack.pop_back());
          else latch_fault(ST_WRONG_KIND, k);
        end
      end
      if (char_idx != '1) char_idx++;
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [STAT_W-1:0] st, logic [POS_W-1:0] pos, logic [KIND_W-1:0] k);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        report($sformatf("result with none pending: status %0d position %0d kind %0d",
                         st, pos, k));
        return;
      end
      want = verdict_q.pop_front();
      verdicts_checked++;
      if (want.status < 5) status_tally[want.status]++;
      if (st !== want.status)
        report($sformatf("result %0d status %0d, expected %0d", verdicts_checked, st,
                         want.status));
      if (pos !== want.pos)
        report($sformatf("result %0d position %0d, expected %0d", verdicts_checked, pos,
                         want.pos));
      if (k !== want.kind)
        report($sformatf("result %0d bracket_kind %0d, expected %0d", verdicts_checked, k,
                         want.kind));
    endtask
  endclass

  logic                clk;
  logic                rst          = 1'b1;
  logic                char_valid   = 1'b0;
  logic                char_stall;
  logic [7:0]          ch           = 8'h00;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [POS_W-1:0]    position;
  logic [KIND_W-1:0]   bracket_kind;

  logic                quiet        = 1'b0;
  logic                hold_go      = 1'b0;
  logic                hold_off     = 1'b0;
  int                  cycle_count  = 0;
  int                  chars_sent   = 0;

  bracket_scoreboard ledger = new();

  bracket_balance_checker dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .ch           (ch),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .position     (position),
    .bracket_kind (bracket_kind)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] opener(logic [KIND_W-1:0] k);
    case (k)
      KIND_ROUND: return CH_RND_OPEN;
      KIND_CURLY: return CH_CRL_OPEN;
      default:    return CH_SQR_OPEN;
    endcase
  endfunction

  function automatic logic [7:0] closer(logic [KIND_W-1:0] k);
    case (k)
      KIND_ROUND: return CH_RND_CLOSE;
      KIND_CURLY: return CH_CRL_CLOSE;
      default:    return CH_SQR_CLOSE;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] any_kind();
    return KIND_W'($urandom_range(2));
  endfunction

  function automatic logic [7:0] filler();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255, 1));
    end while (c == CH_RND_OPEN || c == CH_RND_CLOSE || c == CH_CRL_OPEN ||
               c == CH_CRL_CLOSE || c == CH_SQR_OPEN || c == CH_SQR_CLOSE);
    return c;
  endfunction

  function automatic void make_expression(ref logic [7:0] text[$], input int max_len,
                                          input int max_nest);
    logic [KIND_W-1:0] kinds[$];
    logic [KIND_W-1:0] k;
    int                len;
    int                mode;
    int                r;
    text.delete();
    len  = $urandom_range(max_len, 1);
    mode = $urandom_range(99);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (mode >= 88) begin
        text.push_back(8'($urandom_range(255, 1)));
      end else if (r < 35 && kinds.size() < max_nest) begin
        k = any_kind();
        kinds.push_back(k);
        text.push_back(opener(k));
      end else if (r < 70 && kinds.size() > 0) begin
        k = kinds.pop_back();
        if (mode >= 70 && mode < 80 && $urandom_range(3) == 0)
          k = KIND_W'((k + 1 + $urandom_range(1)) % 3);
        text.push_back(closer(k));
      end else if (r < 75 && mode >= 80) begin
        text.push_back(closer(any_kind()));
      end else begin
        text.push_back(filler());
      end
    end
    if (mode < 60 || (mode >= 70 && mode < 88))
      while (kinds.size() > 0) text.push_back(closer(kinds.pop_back()));
    if (mode >= 80 && mode < 88 && $urandom_range(1) == 1)
      text.push_front(closer(any_kind()));
  endfunction

  task automatic send_char(input logic [7:0] c);
    while (!quiet && $urandom_range(99) < 34) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    ch         <= c;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    ledger.note_char(c);
    chars_sent++;
  endtask

  task automatic send_expression(ref logic [7:0] text[$]);
    foreach (text[i]) send_char(text[i]);
    send_char(CH_TERM);
  endtask

  task automatic send_deep(input int opens, input bit close_all);
    logic [7:0]        text[$];
    logic [KIND_W-1:0] kinds[$];
    logic [KIND_W-1:0] k;
    repeat (opens) begin
      k = any_kind();
      kinds.push_back(k);
      text.push_back(opener(k));
    end
    if (close_all)
      while (kinds.size() > 0) text.push_back(closer(kinds.pop_back()));
    send_expression(text);
  endtask

  initial begin
    logic [7:0] text[$];
    int         random_chars;
    int         n;
    random_chars = 0;
    n            = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    text.delete();
    send_expression(text);
    text = '{CH_RND_OPEN, CH_SQR_OPEN, CH_CRL_OPEN, CH_CRL_CLOSE, CH_SQR_CLOSE, CH_RND_CLOSE};
    send_expression(text);
    text = '{CH_RND_CLOSE};
    send_expression(text);
    text = '{CH_RND_OPEN, CH_SQR_CLOSE};
    send_expression(text);
    text = '{CH_SQR_OPEN, CH_RND_OPEN};
    send_expression(text);
    text = '{CH_CRL_CLOSE, CH_SQR_CLOSE, 8'h80};
    send_expression(text);
    text = '{8'hff, CH_CRL_OPEN};
    send_expression(text);

    send_deep(STACK_DEPTH, 1'b1);
    send_deep(STACK_DEPTH + 1, 1'b0);
    send_deep(STACK_DEPTH, 1'b0);

    while (random_chars < RANDOM_CHARS) begin
      if (n == 12) hold_go <= 1'b1;
      quiet <= (random_chars >= 200 && random_chars < 350);
      make_expression(text, 24, 8);
      send_expression(text);
      random_chars += text.size() + 1;
      n++;
    end
    char_valid <= 1'b0;

    while (ledger.verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d characters in %0d expressions; checked %0d results, %0d mismatches.",
             chars_sent, ledger.expressions, ledger.verdicts_checked, ledger.mismatches);
    $display("Results by status: balanced %0d, close on empty %0d, wrong kind %0d, %s %0d, %s %0d.",
             ledger.status_tally[ST_BALANCED], ledger.status_tally[ST_CLOSE_EMPTY],
             ledger.status_tally[ST_WRONG_KIND], "unclosed", ledger.status_tally[ST_UNCLOSED],
             "overflow", ledger.status_tally[ST_OVERFLOW]);
    if (ledger.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall)
        ledger.check_result(status, position, bracket_kind);
      if (hold_off) result_stall <= 1'b1;
      else if (quiet) result_stall <= 1'b0;
      else result_stall <= ($urandom_range(99) < 34);
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
             ledger.verdict_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
